FILE: src/tedq_pkg.sv
// tedq_pkg: shared types and constants for the timer event deadline queue
// no dependencies
package tedq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam logic [15:0] TPM_RESET = 16'd1;
  localparam logic [31:0] LOAD_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] KIND_SCHED  = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic        valid;
    logic [47:0] etime;
    logic [7:0]  owner;
    logic [31:0] msg;
  } slot_t;

  // command broadcast to every cell
  typedef struct packed {
    logic        ins;     // insert new entry
    logic        pop;     // shift whole row towards head
    logic        cancel;  // compact out entries of owner
    slot_t       din;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WORK, ST_FIRE, ST_MUL, ST_FIN
  } state_t;

endpackage

FILE: src/tedq_cell.sv
// tedq_cell: one slot of the sorted event row
// depends on tedq_pkg
module tedq_cell (
  input  logic               clk,
  input  logic               rst,
  input  tedq_pkg::cell_cmd_t cmd,
  input  tedq_pkg::slot_t    prev,      // neighbour nearer the head
  input  logic               prev_goes, // new entry sorts at or before prev, so prev shifts into this cell
  input  logic               prev_kill, // cancel count in front of this cell is nonzero
  input  tedq_pkg::slot_t    next,      // neighbour further from head
  output tedq_pkg::slot_t    q,
  output logic               goes,      // new entry sorts at or before here
  output logic               kill       // this or an earlier cell cancels
);

  logic hit;
  logic ahead;

  // new entry goes before this slot when slot is empty or strictly later
  assign ahead = !q.valid || (q.etime > cmd.din.etime);
  assign goes  = ahead;
  assign hit   = q.valid && (q.owner == cmd.din.owner);
  assign kill  = hit || prev_kill;

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (cmd.ins) begin
      if (ahead && prev_goes) q <= prev;
      else if (ahead) q <= cmd.din;
    end else if (cmd.pop) begin
      q <= next;
    end else if (cmd.cancel) begin
      // remove one matching entry per cycle: cells at or after first hit shift
      if (kill) q <= next;
    end
  end

endmodule

FILE: src/tedq_rearm.sv
// tedq_rearm: deadline select and tick conversion with saturation
// depends on tedq_pkg
module tedq_rearm (
  input  logic        clk,
  input  logic        start,
  input  logic [47:0] now_time,
  input  logic [47:0] slice_deadline,
  input  tedq_pkg::slot_t head,
  input  logic [15:0] tpm,
  output logic        armed,
  output logic [31:0] load
);

  logic [47:0] dl;
  logic [47:0] wait_us;
  logic [47:0] wait_r;
  logic        armed_r;
  logic [15:0] tpm_eff;
  logic [63:0] prod;

  always_comb begin
    dl = slice_deadline;
    if (head.valid && (dl == 48'd0 || head.etime < dl)) dl = head.etime;
    wait_us = (dl > now_time) ? dl - now_time : 48'd0;
    if (wait_us == 48'd0) wait_us = 48'd1;
  end

  assign tpm_eff = (tpm == 16'd0) ? 16'd1 : tpm;
  // wait above 32 bits always saturates, so only 33 bits reach the multiplier
  assign prod = {31'd0, wait_r[32:0]} * {48'd0, tpm_eff};

  always_ff @(posedge clk) begin
    if (start) begin
      wait_r  <= wait_us;
      armed_r <= (dl != 48'd0);
    end
  end

  always_comb begin
    armed = armed_r;
    if (!armed_r) load = '0;
    else if (wait_r[47:32] != 16'd0 || prod[63:32] != 32'd0) load = tedq_pkg::LOAD_MAX;
    else load = prod[31:0];
  end

endmodule

FILE: src/timer_event_deadline_queue.sv
// timer_event_deadline_queue: top level, control sequencer and output register
// depends on tedq_pkg, tedq_cell, tedq_rearm
//
// A time-ordered row of CAPACITY cells holds pending timer events; every cell
// compares the broadcast entry with its own and takes its neighbour's content
// in the same cycle, so the whole row shifts together on an insert. A schedule
// beat runs through insert, deadline select and multiply into the output
// register, and the next beat is taken once the sequencer is back in idle. A
// tick beat adds a pop per fired event, each pop shifting the whole row towards
// the head. A cancel beat adds a compaction step per matching event, removing
// the first match each cycle. A waiting result that is not taken stalls the fire
// pops and the final result. The final result carries last=1 and the re-arm
// values; the wait is multiplied by ticks_per_microsecond in a 33x16 multiply
// fed from a register and saturates at all ones. One beat is in work at a
// time; a result waits in the output register until taken.
module timer_event_deadline_queue #(
  parameter int CAPACITY = tedq_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [47:0] now_time,
  input  logic [47:0] trigger_time,
  input  logic [7:0]  owner_id,
  input  logic [31:0] message_code,
  input  logic [47:0] slice_deadline,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        fired,
  output logic [7:0]  fired_owner,
  output logic [31:0] fired_message,
  output logic        dropped,
  output logic        timer_armed,
  output logic [31:0] load_count,
  output logic        last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  tedq_pkg::state_t state, state_next;
  tedq_pkg::cell_cmd_t cmd;
  tedq_pkg::slot_t slot [CAPACITY];
  tedq_pkg::slot_t empty_slot;
  logic [CAPACITY-1:0] goes, kill;

  logic [15:0] tpm;
  logic [1:0]  kind_r;
  logic [47:0] now_r, slice_r;
  logic [7:0]  owner_r;
  logic [31:0] msg_r;
  logic [47:0] etime_r;
  logic        drop_r;
  logic        rearm_start;
  logic        armed;
  logic [31:0] load;
  logic        out_free;
  logic        due;

  assign empty_slot = '0;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == tedq_pkg::ST_IDLE);
  assign due = slot[0].valid && (slot[0].etime <= now_r);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) tpm <= tedq_pkg::TPM_RESET;
    else if (cfg_we) tpm <= cfg_wdata;
  end

  // capture the beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r  <= kind;
      now_r   <= now_time;
      slice_r <= slice_deadline;
      owner_r <= owner_id;
      msg_r   <= message_code;
      etime_r <= trigger_time;
      drop_r  <= (kind == tedq_pkg::KIND_SCHED) && slot[CAPACITY-1].valid;
    end
  end

  // the row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    tedq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .prev      ((g == 0) ? empty_slot : slot[(g == 0) ? 0 : g-1]),
      .prev_goes ((g == 0) ? 1'b0 : goes[(g == 0) ? 0 : g-1]),
      .prev_kill ((g == 0) ? 1'b0 : kill[(g == 0) ? 0 : g-1]),
      .next      ((g == CAPACITY-1) ? empty_slot : slot[(g == CAPACITY-1) ? g : g+1]),
      .q         (slot[g]),
      .goes      (goes[g]),
      .kill      (kill[g])
    );
  end

  tedq_rearm u_rearm (
    .clk            (clk),
    .start          (rearm_start),
    .now_time       (now_r),
    .slice_deadline (slice_r),
    .head           (slot[0]),
    .tpm            (tpm),
    .armed          (armed),
    .load           (load)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= tedq_pkg::ST_IDLE;
    else state <= state_next;
  end

  // sequencer: work phase, then fire loop, then re-arm
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.din     = '{valid: 1'b1, etime: etime_r, owner: owner_r, msg: msg_r};
    rearm_start = 1'b0;
    case (state)
      tedq_pkg::ST_IDLE: if (in_valid) state_next = tedq_pkg::ST_WORK;
      tedq_pkg::ST_WORK: begin
        case (kind_r)
          tedq_pkg::KIND_SCHED: begin
            cmd.ins = !drop_r;
            state_next = tedq_pkg::ST_FIRE;
          end
          tedq_pkg::KIND_CANCEL: begin
            if (kill[CAPACITY-1]) cmd.cancel = 1'b1;
            else state_next = tedq_pkg::ST_FIRE;
          end
          default: state_next = tedq_pkg::ST_FIRE;
        endcase
      end
      tedq_pkg::ST_FIRE: begin
        if (kind_r == tedq_pkg::KIND_TICK && due) begin
          if (out_free) cmd.pop = 1'b1;
        end else begin
          rearm_start = 1'b1;
          state_next = tedq_pkg::ST_MUL;
        end
      end
      tedq_pkg::ST_MUL: if (out_free) state_next = tedq_pkg::ST_IDLE;
      default: state_next = tedq_pkg::ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pop) begin
      out_valid     <= 1'b1;
      fired         <= 1'b1;
      fired_owner   <= slot[0].owner;
      fired_message <= slot[0].msg;
      dropped       <= 1'b0;
      timer_armed   <= 1'b0;
      load_count    <= '0;
      last          <= 1'b0;
    end else if (state == tedq_pkg::ST_MUL && out_free) begin
      out_valid     <= 1'b1;
      fired         <= 1'b0;
      fired_owner   <= '0;
      fired_message <= '0;
      dropped       <= drop_r;
      timer_armed   <= armed;
      load_count    <= load;
      last          <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // an accepted beat is never taken while the row is still busy
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == tedq_pkg::ST_IDLE)) else $error("ready outside idle");
  // a fire pop only shifts a due head
  a_pop_due: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (slot[0].valid && slot[0].etime <= now_r)) else $error("pop not due");
  // a fire result is never the final one
  a_fire_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fired) |-> !last) else $error("fire marked last");
  // the re-arm result closes the beat
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == tedq_pkg::ST_MUL && out_free) |=> (out_valid && last))
    else $error("missing final result");

endmodule
